>>> sv/fdr_pkg.sv
// ---------------------------------------------------------------------------
// fdr_pkg
// Constants and types shared by the Fresnel reflectance pipeline.
// ---------------------------------------------------------------------------
package fdr_pkg;

   localparam logic [28:0] Q28_ONE = 29'h1000_0000;
   localparam logic [15:0] Q15_ONE = 16'h8000;

   localparam int DIV1_STEPS = 29;   // quotient bits of sin^2 T
   localparam int SQRT_STEPS = 16;   // root bits of cos T
   localparam int DIV2_STEPS = 31;   // quotient bits of each amplitude ratio

   // side data carried alongside the sin^2 T divider and the square root
   typedef struct packed {
      logic [14:0] eta_i;
      logic [14:0] eta_t;
      logic [15:0] c_i;
      logic        tir;
      logic        dz;     // transmitted index squared is zero
   } side_type;

   // side data carried alongside the ratio dividers
   typedef struct packed {
      logic tir;
      logic zden;
   } rt_side_type;

endpackage

>>> sv/fresnel_dielectric_reflectance_unit.sv
// ---------------------------------------------------------------------------
// fresnel_dielectric_reflectance_unit
// Unpolarized Fresnel reflectance of a dielectric boundary, fully pipelined.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low, the receiver cannot stall.
// The pipeline holds bit-per-stage dividers (29 + 31 stages) and a square root (16 stages).
// Reset: synchronous, clears all valid bits; items in flight are dropped.
// Payload registers are not reset.
module fresnel_dielectric_reflectance_unit
   import fdr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_inc_x,
   input  logic signed [15:0] req_inc_y,
   input  logic signed [15:0] req_inc_z,
   input  logic signed [15:0] req_nrm_x,
   input  logic signed [15:0] req_nrm_y,
   input  logic signed [15:0] req_nrm_z,
   input  logic        [14:0] req_index_outside,
   input  logic        [14:0] req_index_inside,
   output logic               rsp_valid,
   output logic        [15:0] rsp_reflectance,
   output logic               rsp_total_reflect
);

   assign busy = 1'b0;

   // ---- stage 1: component products ------------------------------------
   logic               s1_v_ff;
   logic signed [31:0] s1_p_ff [0:2];
   logic        [14:0] s1_eo_ff, s1_ei_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= start;
      end
      s1_p_ff[0] <= req_inc_x * req_nrm_x;
      s1_p_ff[1] <= req_inc_y * req_nrm_y;
      s1_p_ff[2] <= req_inc_z * req_nrm_z;
      s1_eo_ff   <= req_index_outside;
      s1_ei_ff   <= req_index_inside;
   end

   // ---- stage 2: dot product, side swap, |cos I| clamped to 1.0 ---------
   logic signed [33:0] dot_in;
   logic        [33:0] dot_abs_in;
   logic        [28:0] c28_in;
   logic               s2_v_ff;
   logic        [28:0] s2_c28_ff;
   logic        [14:0] s2_eta_i_ff, s2_eta_t_ff;

   always_comb begin
      dot_in     = 34'(s1_p_ff[0]) + 34'(s1_p_ff[1]) + 34'(s1_p_ff[2]);
      dot_abs_in = dot_in[33] ? 34'(-dot_in) : dot_in;
      c28_in     = (dot_abs_in > 34'(Q28_ONE)) ? Q28_ONE : dot_abs_in[28:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_c28_ff <= c28_in;
      // positive dot: ray exits, indices trade places
      if (!dot_in[33] && (dot_in != '0)) begin
         s2_eta_i_ff <= s1_ei_ff;
         s2_eta_t_ff <= s1_eo_ff;
      end else begin
         s2_eta_i_ff <= s1_eo_ff;
         s2_eta_t_ff <= s1_ei_ff;
      end
   end

   // ---- stage 3: squares, cos I in Q.15 -----------------------------------
   logic [28:0] ci_sum_in;
   logic [15:0] ci_in;
   logic        s3_v_ff;
   logic [57:0] s3_cc_ff;
   logic [29:0] s3_ei2_ff, s3_et2_ff;
   logic [15:0] s3_ci_ff;
   logic [14:0] s3_eta_i_ff, s3_eta_t_ff;

   always_comb begin
      ci_sum_in = s2_c28_ff + 29'd4096;
      ci_in     = (ci_sum_in[28:13] > Q15_ONE) ? Q15_ONE : ci_sum_in[28:13];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_cc_ff    <= s2_c28_ff * s2_c28_ff;
      s3_ei2_ff   <= s2_eta_i_ff * s2_eta_i_ff;
      s3_et2_ff   <= s2_eta_t_ff * s2_eta_t_ff;
      s3_ci_ff    <= ci_in;
      s3_eta_i_ff <= s2_eta_i_ff;
      s3_eta_t_ff <= s2_eta_t_ff;
   end

   // ---- stage 4: sin^2 I = 1 - cos^2 I ----------------------------------
   logic        s4_v_ff;
   logic [28:0] s4_s28_ff;
   logic [29:0] s4_ei2_ff, s4_et2_ff;
   side_type    s4_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else begin
         s4_v_ff <= s3_v_ff;
      end
      s4_s28_ff      <= 29'(30'(Q28_ONE) - s3_cc_ff[57:28]);
      s4_ei2_ff      <= s3_ei2_ff;
      s4_et2_ff      <= s3_et2_ff;
      s4_sd_ff.eta_i <= s3_eta_i_ff;
      s4_sd_ff.eta_t <= s3_eta_t_ff;
      s4_sd_ff.c_i   <= s3_ci_ff;
      s4_sd_ff.tir   <= 1'b0;
      s4_sd_ff.dz    <= (s3_et2_ff == '0);
   end

   // ---- stage 5: etaI^2 * sin^2 I ----------------------------------------
   logic        s5_v_ff;
   logic [58:0] s5_nums_ff;
   logic [29:0] s5_et2_ff;
   side_type    s5_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else begin
         s5_v_ff <= s4_v_ff;
      end
      s5_nums_ff <= s4_ei2_ff * s4_s28_ff;
      s5_et2_ff  <= s4_et2_ff;
      s5_sd_ff   <= s4_sd_ff;
   end

   // ---- stage 6: TIR test, load the sin^2 T divider ----------------------
   // long division, one quotient bit per stage; quotient fits 29 bits
   // whenever there is no TIR
   side_type    sd6_in;
   logic        d1_v_ff   [0:DIV1_STEPS];
   logic [29:0] d1_rem_ff [0:DIV1_STEPS];
   logic [28:0] d1_lo_ff  [0:DIV1_STEPS];
   logic [28:0] d1_q_ff   [0:DIV1_STEPS];
   logic [29:0] d1_d_ff   [0:DIV1_STEPS];
   side_type    d1_sd_ff  [0:DIV1_STEPS];

   always_comb begin
      sd6_in     = s5_sd_ff;
      sd6_in.tir = (s5_nums_ff > {1'b0, s5_et2_ff, 28'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_v_ff[0] <= 1'b0;
      end else begin
         d1_v_ff[0] <= s5_v_ff;
      end
      d1_rem_ff[0] <= s5_nums_ff[58:29];
      d1_lo_ff[0]  <= s5_nums_ff[28:0];
      d1_q_ff[0]   <= '0;
      d1_d_ff[0]   <= s5_et2_ff;
      d1_sd_ff[0]  <= sd6_in;
   end

   for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
      logic [30:0] trial_in;
      logic        ge_in;
      assign trial_in = {d1_rem_ff[k], d1_lo_ff[k][DIV1_STEPS-1-k]};
      assign ge_in    = (trial_in >= {1'b0, d1_d_ff[k]});
      always_ff @(posedge clock) begin
         if (reset) begin
            d1_v_ff[k+1] <= 1'b0;
         end else begin
            d1_v_ff[k+1] <= d1_v_ff[k];
         end
         d1_rem_ff[k+1] <= ge_in ? 30'(trial_in - {1'b0, d1_d_ff[k]}) : trial_in[29:0];
         d1_lo_ff[k+1]  <= d1_lo_ff[k];
         d1_q_ff[k+1]   <= {d1_q_ff[k][27:0], ge_in};
         d1_d_ff[k+1]   <= d1_d_ff[k];
         d1_sd_ff[k+1]  <= d1_sd_ff[k];
      end
   end

   // ---- cos^2 T = 1 - sin^2 T, load the square root ----------------------
   logic [28:0] sint2_in;
   logic [28:0] cost2_in;
   logic        sq_v_ff    [0:SQRT_STEPS];
   logic [31:0] sq_x_ff    [0:SQRT_STEPS];
   logic [17:0] sq_rem_ff  [0:SQRT_STEPS];
   logic [15:0] sq_root_ff [0:SQRT_STEPS];
   side_type    sq_sd_ff   [0:SQRT_STEPS];

   always_comb begin
      if (d1_sd_ff[DIV1_STEPS].dz) begin
         sint2_in = '0;
      end else if (d1_q_ff[DIV1_STEPS] > Q28_ONE) begin
         sint2_in = Q28_ONE;
      end else begin
         sint2_in = d1_q_ff[DIV1_STEPS];
      end
      cost2_in = Q28_ONE - sint2_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else begin
         sq_v_ff[0] <= d1_v_ff[DIV1_STEPS];
      end
      sq_x_ff[0]    <= {1'b0, cost2_in, 2'b00};
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
      sq_sd_ff[0]   <= d1_sd_ff[DIV1_STEPS];
   end

   // restoring square root, two radicand bits per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [19:0] rsh_in;
      logic [19:0] trial_in;
      logic        ge_in;
      assign rsh_in   = {sq_rem_ff[k], sq_x_ff[k][31-2*k -: 2]};
      assign trial_in = {2'b00, sq_root_ff[k], 2'b01};
      assign ge_in    = (rsh_in >= trial_in);
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         sq_rem_ff[k+1]  <= ge_in ? 18'(rsh_in - trial_in) : rsh_in[17:0];
         sq_root_ff[k+1] <= {sq_root_ff[k][14:0], ge_in};
         sq_x_ff[k+1]    <= sq_x_ff[k];
         sq_sd_ff[k+1]   <= sq_sd_ff[k];
      end
   end

   // ---- amplitude terms: etaT*cI, etaI*cT, etaI*cI, etaT*cT ---------------
   logic [15:0] ct_in;
   side_type    sqo_sd;
   logic        pr_v_ff;
   logic [30:0] pr_a_ff [0:1];
   logic [30:0] pr_b_ff [0:1];
   logic        pr_tir_ff;

   always_comb begin
      sqo_sd = sq_sd_ff[SQRT_STEPS];
      ct_in  = (sq_root_ff[SQRT_STEPS] > Q15_ONE) ? Q15_ONE : sq_root_ff[SQRT_STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_v_ff <= 1'b0;
      end else begin
         pr_v_ff <= sq_v_ff[SQRT_STEPS];
      end
      pr_a_ff[0] <= sqo_sd.eta_t * sqo_sd.c_i;   // parallel
      pr_b_ff[0] <= sqo_sd.eta_i * ct_in;
      pr_a_ff[1] <= sqo_sd.eta_i * sqo_sd.c_i;   // perpendicular
      pr_b_ff[1] <= sqo_sd.eta_t * ct_in;
      pr_tir_ff  <= sqo_sd.tir;
   end

   // ---- |a-b| / (a+b), two lanes of long division ----------------------------
   logic [31:0] den_in [0:1];
   logic [30:0] mag_in [0:1];
   rt_side_type rt0_in;
   logic        d2_v_ff  [0:DIV2_STEPS];
   rt_side_type d2_sd_ff [0:DIV2_STEPS];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         den_in[j] = {1'b0, pr_a_ff[j]} + {1'b0, pr_b_ff[j]};
         mag_in[j] = (pr_a_ff[j] >= pr_b_ff[j]) ? pr_a_ff[j] - pr_b_ff[j]
                                                : pr_b_ff[j] - pr_a_ff[j];
      end
      rt0_in.tir  = pr_tir_ff;
      rt0_in.zden = (den_in[0] == '0) || (den_in[1] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_v_ff[0] <= 1'b0;
      end else begin
         d2_v_ff[0] <= pr_v_ff;
      end
      d2_sd_ff[0] <= rt0_in;
   end

   for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            d2_v_ff[k+1] <= 1'b0;
         end else begin
            d2_v_ff[k+1] <= d2_v_ff[k];
         end
         d2_sd_ff[k+1] <= d2_sd_ff[k];
      end
   end

   logic [30:0] q_out [0:1];

   for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [31:0] rem_ff [0:DIV2_STEPS];
      logic [30:0] lo_ff  [0:DIV2_STEPS];
      logic [30:0] q_ff   [0:DIV2_STEPS];
      logic [31:0] d_ff   [0:DIV2_STEPS];

      // dividend is mag shifted up 30 places
      always_ff @(posedge clock) begin
         rem_ff[0] <= {2'b00, mag_in[j][30:1]};
         lo_ff[0]  <= {mag_in[j][0], 30'd0};
         q_ff[0]   <= '0;
         d_ff[0]   <= den_in[j];
      end

      for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_step
         logic [32:0] trial_in;
         logic        ge_in;
         assign trial_in = {rem_ff[k], lo_ff[k][DIV2_STEPS-1-k]};
         assign ge_in    = (trial_in >= {1'b0, d_ff[k]});
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge_in ? 32'(trial_in - {1'b0, d_ff[k]}) : trial_in[31:0];
            lo_ff[k+1]  <= lo_ff[k];
            q_ff[k+1]   <= {q_ff[k][29:0], ge_in};
            d_ff[k+1]   <= d_ff[k];
         end
      end

      assign q_out[j] = q_ff[DIV2_STEPS];
   end

   // ---- squares of the ratios --------------------------------------------
   logic        sqr_v_ff;
   logic [61:0] sqr_ff [0:1];
   rt_side_type sqr_sd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqr_v_ff <= 1'b0;
      end else begin
         sqr_v_ff <= d2_v_ff[DIV2_STEPS];
      end
      sqr_ff[0] <= q_out[0] * q_out[0];
      sqr_ff[1] <= q_out[1] * q_out[1];
      sqr_sd_ff <= d2_sd_ff[DIV2_STEPS];
   end

   // ---- average, round to Q.15, clamp, special cases ----------------------
   logic [62:0] sum_in;
   logic [15:0] refl_in;
   logic        out_v_ff;
   logic [15:0] out_refl_ff;
   logic        out_tir_ff;

   always_comb begin
      sum_in = {1'b0, sqr_ff[0]} + {1'b0, sqr_ff[1]} + (63'd1 << 45);
      if (sqr_sd_ff.tir || sqr_sd_ff.zden) begin
         refl_in = Q15_ONE;
      end else if (sum_in[62:46] > 17'(Q15_ONE)) begin
         refl_in = Q15_ONE;
      end else begin
         refl_in = sum_in[61:46];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= sqr_v_ff;
      end
      out_refl_ff <= refl_in;
      out_tir_ff  <= sqr_sd_ff.tir;
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_reflectance   = out_refl_ff;
   assign rsp_total_reflect = out_tir_ff;

endmodule
